[design/wwas_pkg.sv]
// shared constants and codes for the weighted window angle smoother
`default_nettype none
package wwas_pkg;
    localparam int PIX_W      = 24;
    localparam int BYTE_W     = 8;
    localparam int QUOT_W     = 8;
    localparam int POS_W      = 10;
    localparam int CFG_W      = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_RADIUS = 2;
    localparam int DEF_MAX_HEIGHT = 1024;
    localparam logic [CFG_W-1:0] RST_FRAME_WIDTH = 11'd640;
    localparam logic [1:0]       RST_RADIUS      = 2'd1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH = 2'd0,
        CFG_RADIUS      = 2'd1,
        CFG_ANGLES_ONLY = 2'd2
    } cfg_idx_t;
endpackage
`default_nettype wire

[design/wwas_ram.sv]
// generic single-write, single-read ram with registered read data
`default_nettype none
module wwas_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 5120
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

[design/wwas_div.sv]
// restoring divider, one quotient bit per cycle, quotient known to fit
`default_nettype none
module wwas_div #(
    parameter int DIVIDEND_W = 22,
    parameter int DIVISOR_W  = 13
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic [DIVIDEND_W-1:0] dividend,
    input  wire logic [DIVISOR_W-1:0]  divisor,
    output logic                       done,
    output logic [wwas_pkg::QUOT_W-1:0] quotient
);
    localparam int QW   = wwas_pkg::QUOT_W;
    localparam int CW   = $clog2(QW);
    localparam int WIDE = DIVIDEND_W + DIVISOR_W + QW;

    logic                  busy_reg;
    logic                  done_reg;
    logic [CW-1:0]         cnt_reg;
    logic [DIVIDEND_W-1:0] rem_reg;
    logic [DIVISOR_W-1:0]  den_reg;
    logic [QW-1:0]         q_reg;
    logic [WIDE-1:0]       trial;
    logic                  fits;

    assign trial = WIDE'(den_reg) << cnt_reg;
    assign fits  = WIDE'(rem_reg) >= trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == '0)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= dividend;
            den_reg <= divisor;
            q_reg   <= '0;
            cnt_reg <= CW'(QW - 1);
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_reg <= DIVIDEND_W'(WIDE'(rem_reg) - trial);
                q_reg   <= q_reg | (QW'(1) << cnt_reg);
            end
            if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - CW'(1);
            end
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;
endmodule
`default_nettype wire

[design/weighted_window_angle_smoother.sv]
// top level: line store, window sequencer, weighted sums and shared divider
//
// channel | dir | handshake         | payload
// s_      | in  | s_tvalid/s_tready | s_tdata: in_magnitude, in_pos_angle, in_neg_angle
//         |     |                   | s_tuser: start_frame
// m_      | out | m_tvalid/m_tready | m_tdata: out_magnitude, out_pos_angle,
//         |     |                   |   out_neg_angle, center_row, center_col
// cfg_    | in  | cfg_wr_en         | cfg_index, cfg_data
//
// a request that yields no result leaves the sequencer in ST_IDLE
// a request with a result reads the (2R+1)^2-pixel window from the line store one pixel
// per cycle, then runs two divisions on the shared divider
// reset clears position counters and configuration; the line store is not cleared
// the result waits in an output register while the next request is accepted
`default_nettype none
module weighted_window_angle_smoother #(
    parameter int MAX_WIDTH  = wwas_pkg::DEF_MAX_WIDTH,
    parameter int MAX_RADIUS = wwas_pkg::DEF_MAX_RADIUS,
    parameter int MAX_HEIGHT = wwas_pkg::DEF_MAX_HEIGHT
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // in_magnitude, in_pos_angle, in_neg_angle
    input  wire logic        s_tuser,   // start_frame
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,   // out_magnitude, out_pos_angle, out_neg_angle,
                                        // center_row, center_col, zero pad
    input  wire logic        cfg_wr_en,
    input  wire logic [wwas_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [wwas_pkg::CFG_W-1:0]     cfg_data
);
    localparam int ROWS_KEPT = 2 * MAX_RADIUS + 1;
    localparam int WIN_AREA  = ROWS_KEPT * ROWS_KEPT;
    localparam int DEPTH     = ROWS_KEPT * MAX_WIDTH;
    localparam int AA        = $clog2(DEPTH);
    localparam int COLW      = $clog2(MAX_WIDTH);
    localparam int ROWW      = $clog2(MAX_HEIGHT);
    localparam int SLW       = $clog2(ROWS_KEPT);
    localparam int RW        = $clog2(MAX_RADIUS + 1);
    localparam int SW        = $clog2(ROWS_KEPT + 1);
    localparam int LW        = $clog2(WIN_AREA * 255 + 1);
    localparam int MW        = $clog2(WIN_AREA * 255 * 255 + 1);
    localparam int AW        = MW + 1;
    localparam int BW        = wwas_pkg::BYTE_W;
    localparam int PW        = wwas_pkg::POS_W;

    typedef enum logic [2:0] {
        ST_IDLE, ST_READ, ST_TAIL, ST_PREP, ST_DIV_MAG, ST_DIV_ANG, ST_OUT
    } state_t;

    // configuration
    logic [wwas_pkg::CFG_W-1:0] frame_width_reg;
    logic [1:0]                 radius_reg;
    logic                       angles_only_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg <= wwas_pkg::RST_FRAME_WIDTH;
            radius_reg      <= wwas_pkg::RST_RADIUS;
            angles_only_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            case (wwas_pkg::cfg_idx_t'(cfg_index))
                wwas_pkg::CFG_FRAME_WIDTH: frame_width_reg <= cfg_data;
                wwas_pkg::CFG_RADIUS:      radius_reg      <= cfg_data[1:0];
                wwas_pkg::CFG_ANGLES_ONLY: angles_only_reg <= cfg_data[0];
                default:                   ;
            endcase
        end
    end

    // clamped width and radius
    logic [wwas_pkg::CFG_W:0] eff_w;
    logic [RW-1:0]            eff_rad;
    always_comb
    begin
        if (frame_width_reg == '0)
            eff_w = (wwas_pkg::CFG_W + 1)'(1);
        else if ((wwas_pkg::CFG_W + 1)'(frame_width_reg) > (wwas_pkg::CFG_W + 1)'(MAX_WIDTH))
            eff_w = (wwas_pkg::CFG_W + 1)'(MAX_WIDTH);
        else
            eff_w = (wwas_pkg::CFG_W + 1)'(frame_width_reg);
        if (radius_reg == 2'd0)
            eff_rad = RW'(1);
        else if (32'(radius_reg) > MAX_RADIUS)
            eff_rad = RW'(MAX_RADIUS);
        else
            eff_rad = RW'(radius_reg);
    end

    // raster position of the next pixel
    logic [ROWW-1:0] row_reg;
    logic [COLW-1:0] col_reg;
    logic [SLW-1:0]  slot_reg;
    logic [ROWW-1:0] cur_row;
    logic [COLW-1:0] cur_col;
    logic [SLW-1:0]  cur_slot;
    logic            col_wrap;
    logic            row_wrap;
    logic            produce;
    logic [SW-1:0]   two_rad;

    assign cur_row  = s_tuser ? '0 : row_reg;
    assign cur_col  = s_tuser ? '0 : col_reg;
    assign cur_slot = s_tuser ? '0 : slot_reg;
    assign col_wrap = (32'(cur_col) + 1) >= 32'(eff_w);
    assign row_wrap = (32'(cur_row) + 1) >= MAX_HEIGHT;
    assign two_rad  = SW'(eff_rad) << 1;
    assign produce  = (32'(cur_row) >= 32'(two_rad)) && (32'(cur_col) >= 32'(two_rad));

    state_t state_reg;
    logic   accept;
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    // line store
    logic [AA-1:0]              waddr;
    logic [AA-1:0]              raddr;
    logic [wwas_pkg::PIX_W-1:0] rdata;
    logic [SLW-1:0]             rd_slot_reg;
    logic [COLW-1:0]            rd_col_reg;
    logic [COLW-1:0]            col_start_reg;
    logic [SW-1:0]              k_reg;
    logic [SW-1:0]              l_reg;
    logic [SW-1:0]              side_reg;
    logic                       rd_pend_reg;

    assign waddr = AA'(cur_slot) * AA'(MAX_WIDTH) + AA'(cur_col);
    assign raddr = AA'(rd_slot_reg) * AA'(MAX_WIDTH) + AA'(rd_col_reg);

    wwas_ram #(
        .WIDTH (wwas_pkg::PIX_W),
        .DEPTH (DEPTH)
    ) u_line_store (
        .clk   (clk),
        .we    (accept),
        .waddr (waddr),
        .wdata (s_tdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    // oldest window row slot, modulo the rows kept
    logic [SLW-1:0] first_slot;
    always_comb
    begin
        if (32'(cur_slot) >= 32'(two_rad))
            first_slot = SLW'(32'(cur_slot) - 32'(two_rad));
        else
            first_slot = SLW'(32'(cur_slot) + ROWS_KEPT - 32'(two_rad));
    end

    // weighted sums
    logic [LW-1:0]        sum_len_reg;
    logic signed [AW-1:0] sum_ang_reg;
    logic [BW-1:0]        px_m;
    logic [BW-1:0]        px_p;
    logic [BW-1:0]        px_n;
    logic [2*BW-1:0]      prod;

    assign px_m = rdata[BW-1:0];
    assign px_p = rdata[2*BW-1:BW];
    assign px_n = rdata[3*BW-1:2*BW];
    assign prod = px_m * ((px_p != '0) ? px_p : px_n);

    // shared divider
    localparam int QUOT_BITS = wwas_pkg::QUOT_W;
    logic [MW-1:0]        div_dividend;
    logic [LW-1:0]        div_divisor;
    logic                 div_start;
    logic                 div_done;
    logic [QUOT_BITS-1:0] div_q;
    logic [MW-1:0]        ang_abs;
    logic [LW-1:0]        area_reg;

    assign ang_abs = sum_ang_reg[AW-1] ? MW'(-sum_ang_reg) : MW'(sum_ang_reg);

    always_comb
    begin
        div_start    = 1'b0;
        div_dividend = MW'(sum_len_reg);
        div_divisor  = area_reg;
        case (state_reg)
            ST_PREP:
            begin
                div_start = 1'b1;
            end
            ST_DIV_MAG:
            begin
                div_start    = div_done;
                div_dividend = ang_abs;
                div_divisor  = sum_len_reg;
            end
            default: ;
        endcase
    end

    wwas_div #(
        .DIVIDEND_W (MW),
        .DIVISOR_W  (LW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    // per-result context
    logic [PW-1:0]   ctr_row_reg;
    logic [PW-1:0]   ctr_col_reg;
    logic            ang_only_lat_reg;
    logic [BW-1:0]   mag_q_reg;
    logic [BW-1:0]   ang_q_reg;
    logic            m_tvalid_reg;
    logic [47:0]     m_tdata_reg;
    logic [BW-1:0]   o_mag;
    logic [BW-1:0]   o_pos;
    logic [BW-1:0]   o_neg;
    logic            last_rd;
    logic            out_free;

    assign last_rd  = (k_reg == side_reg - SW'(1)) && (l_reg == side_reg - SW'(1));
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb
    begin
        o_mag = '0;
        o_pos = '0;
        o_neg = '0;
        if (sum_len_reg != '0)
        begin
            if (!ang_only_lat_reg)
                o_mag = mag_q_reg;
            if (!sum_ang_reg[AW-1] && sum_ang_reg != '0)
                o_pos = ang_q_reg;
            else if (sum_ang_reg[AW-1])
                o_neg = ang_q_reg;
        end
    end

    // sequencer: state and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            row_reg      <= '0;
            col_reg      <= '0;
            slot_reg     <= '0;
            rd_pend_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            rd_pend_reg <= (state_reg == ST_READ);
            if (m_tvalid_reg && m_tready && state_reg != ST_OUT)
                m_tvalid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        if (col_wrap)
                        begin
                            col_reg <= '0;
                            if (row_wrap)
                            begin
                                row_reg  <= '0;
                                slot_reg <= '0;
                            end
                            else
                            begin
                                row_reg  <= cur_row + ROWW'(1);
                                slot_reg <= (32'(cur_slot) == ROWS_KEPT - 1) ? '0
                                                                              : cur_slot + SLW'(1);
                            end
                        end
                        else
                        begin
                            row_reg  <= cur_row;
                            slot_reg <= cur_slot;
                            col_reg  <= cur_col + COLW'(1);
                        end
                        if (produce)
                            state_reg <= ST_READ;
                    end
                end
                ST_READ:
                begin
                    if (last_rd)
                        state_reg <= ST_TAIL;
                end
                ST_TAIL:    state_reg <= ST_PREP;
                ST_PREP:    state_reg <= ST_DIV_MAG;
                ST_DIV_MAG:
                begin
                    if (div_done)
                        state_reg <= ST_DIV_ANG;
                end
                ST_DIV_ANG:
                begin
                    if (div_done)
                        state_reg <= ST_OUT;
                end
                ST_OUT:
                begin
                    if (out_free)
                    begin
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // sequencer: datapath registers
    always_ff @(posedge clk)
    begin
        if (accept && produce)
        begin
            rd_slot_reg      <= first_slot;
            rd_col_reg       <= COLW'(32'(cur_col) - 32'(two_rad));
            col_start_reg    <= COLW'(32'(cur_col) - 32'(two_rad));
            k_reg            <= '0;
            l_reg            <= '0;
            side_reg         <= two_rad + SW'(1);
            area_reg         <= LW'((32'(two_rad) + 1) * (32'(two_rad) + 1));
            ctr_row_reg      <= PW'(32'(cur_row) - 32'(eff_rad));
            ctr_col_reg      <= PW'(32'(cur_col) - 32'(eff_rad));
            ang_only_lat_reg <= angles_only_reg;
            sum_len_reg      <= '0;
            sum_ang_reg      <= '0;
        end
        else
        begin
            if (state_reg == ST_READ)
            begin
                if (l_reg == side_reg - SW'(1))
                begin
                    l_reg       <= '0;
                    k_reg       <= k_reg + SW'(1);
                    rd_col_reg  <= col_start_reg;
                    rd_slot_reg <= (32'(rd_slot_reg) == ROWS_KEPT - 1) ? '0
                                                                         : rd_slot_reg + SLW'(1);
                end
                else
                begin
                    l_reg      <= l_reg + SW'(1);
                    rd_col_reg <= rd_col_reg + COLW'(1);
                end
            end
            if (rd_pend_reg && px_m != '0)
            begin
                sum_len_reg <= sum_len_reg + LW'(px_m);
                if (px_p != '0)
                    sum_ang_reg <= sum_ang_reg + AW'(prod);
                else
                    sum_ang_reg <= sum_ang_reg - AW'(prod);
            end
        end
        if (state_reg == ST_DIV_MAG && div_done)
            mag_q_reg <= div_q;
        if (state_reg == ST_DIV_ANG && div_done)
            ang_q_reg <= div_q;
        if (state_reg == ST_OUT && out_free)
            m_tdata_reg <= {4'd0, ctr_col_reg, ctr_row_reg, o_neg, o_pos, o_mag};
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // no new request while the window is being read
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ || state_reg == ST_TAIL) |-> !s_tready)
        else $error("request accepted during window read");

    // a result appears only after the output state
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(state_reg == ST_OUT))
        else $error("result shown without completed window");

    // once ST_PREP starts the first division, ST_DIV_MAG follows with done still low
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PREP) |=> (state_reg == ST_DIV_MAG && !div_done))
        else $error("divider sequencing broken");

    // column counter stays inside the line store
    assert property (@(posedge clk) disable iff (!rst_n)
        32'(col_reg) < MAX_WIDTH)
        else $error("column counter out of range");
endmodule
`default_nettype wire
